/* hdl/nearest_handle_selector_assert.svh */
// assertion macros for the nearest handle selector
`ifndef NEAREST_HANDLE_SELECTOR_ASSERT_SVH
`define NEAREST_HANDLE_SELECTOR_ASSERT_SVH
// implication checked on every rising clock edge, disabled in reset
`define NHS_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication
`define NHS_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

/* hdl/nhs_pkg.sv */
// ----------------------------------------------------------------------------
// nhs_pkg
// shared constants and the slope normalisation rom
// ----------------------------------------------------------------------------
package nhs_pkg;
    localparam int COORD_BITS    = 15;
    localparam int TABLE_ENTRIES = 200;
    localparam int SLOPE_STEP    = 20;
    localparam int SHORTCUT      = 16;
    localparam int COST_BITS     = 20;
    localparam int KIND_BITS     = 8;
    localparam int NORM_BITS     = 13;

    // round(sqrt(200^2 + (20*i)^2)) for i = 0..200, computed at elaboration
    function automatic logic [NORM_BITS-1:0] norm_entry(input logic [7:0] i);
        longint n;
        longint r;
        longint b;
        n = longint'(TABLE_ENTRIES) * TABLE_ENTRIES
            + longint'(i) * SLOPE_STEP * longint'(i) * SLOPE_STEP;
        r = 0;
        b = 64'd1 << 30;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        if (n > r) r = r + 1;
        return r[NORM_BITS-1:0];
    endfunction
endpackage

/* hdl/nearest_handle_selector.sv */
// ----------------------------------------------------------------------------
// nearest_handle_selector
// flow: a matching sloped item runs setup, 17 root steps and two 40-step divisions, then the compare;
// a shortcut item skips the divisions, a non-matching item is skipped; a last item then waits on the output
// reset: synchronous active low, clears running best and returns to idle; one item at a time
// ----------------------------------------------------------------------------
`include "nearest_handle_selector_assert.svh"
module nearest_handle_selector #(
    parameter int COORD_BITS = nhs_pkg::COORD_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [COORD_BITS-1:0]      i_start_x,
    input  logic signed [COORD_BITS-1:0]      i_start_y,
    input  logic signed [COORD_BITS-1:0]      i_center_x,
    input  logic signed [COORD_BITS-1:0]      i_center_y,
    input  logic [nhs_pkg::KIND_BITS-1:0]     i_wanted_kind,
    input  logic [nhs_pkg::KIND_BITS-1:0]     i_handle_kind,
    input  logic [7:0]                        i_handle_index,
    input  logic signed [COORD_BITS-1:0]      i_handle_x,
    input  logic signed [COORD_BITS-1:0]      i_handle_y,
    input  logic                              i_last_handle,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_found,
    output logic [7:0]                        o_best_index,
    output logic signed [COORD_BITS-1:0]      o_best_x,
    output logic signed [COORD_BITS-1:0]      o_best_y,
    output logic [nhs_pkg::COST_BITS-1:0]     o_best_cost
);
    import nhs_pkg::*;

    localparam int DW  = COORD_BITS + 1;          // difference width
    localparam int SQW = 2 * DW + 2;              // squared distance sum, even
    localparam int RTW = DW + 1;                  // root width
    localparam int RSTEPS = SQW / 2;
    localparam int NW  = DW + 24;                 // numerator magnitude width
    localparam int AW  = 13;                      // clamped slope width
    localparam int CW  = 6;
    localparam int RECIP_STEP = 3277;             // 2^16 / 20, rounded up

    typedef enum logic [3:0] {
        S_IDLE, S_SQ1, S_SQ2, S_ROOT, S_SHORT, S_SDIV, S_NUM1, S_NUM2,
        S_NUM3, S_DDIV, S_CMP, S_OUT
    } t_state;

    t_state r_state;
    logic signed [COORD_BITS-1:0] r_sx, r_sy, r_cx, r_cy, r_hx, r_hy;
    logic [7:0] r_idx;
    logic r_last;
    logic signed [DW-1:0] r_dx, r_dy;
    logic [DW-1:0] r_adx, r_ady;
    logic [SQW-1:0] r_sq;
    logic [SQW-1:0] r_rem_n;
    logic [RTW+1:0] r_root;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_q, r_rem, r_div;
    logic [COST_BITS-1:0] r_d, r_dc;
    logic r_neg;
    logic signed [AW-1:0] r_a;
    logic signed [NW:0] r_prod;
    logic r_have;
    logic [COST_BITS-1:0] r_cost;
    logic [7:0] r_bidx;
    logic signed [COORD_BITS-1:0] r_bx, r_by;

    logic [SQW+1:0] w_trial;
    logic [NW:0] w_sub;
    logic [NW-1:0] w_rem_sh;
    logic [COST_BITS:0] w_sum;
    logic signed [DW-1:0] w_dx, w_dy;
    logic [2*DW-1:0] w_sqx, w_sqy;
    logic signed [DW-1:0] w_cxs, w_syc;
    logic signed [AW+DW-1:0] w_pa;
    logic signed [DW+8:0] w_pb;
    logic [AW-1:0] w_a_mag;
    logic [AW+11:0] w_recip;
    logic [7:0] w_slope_idx;
    logic [NORM_BITS-1:0] w_norm_rom [0:TABLE_ENTRIES];

    // slope normalisation rom
    for (genvar g = 0; g <= TABLE_ENTRIES; g++) begin : g_rom
        assign w_norm_rom[g] = norm_entry(8'(g));
    end

    assign w_dx = DW'(r_hx) - DW'(r_sx);
    assign w_dy = DW'(r_hy) - DW'(r_sy);
    assign w_sqx = r_adx * r_adx;
    assign w_sqy = r_ady * r_ady;
    assign w_cxs = DW'(r_cx) - DW'(r_sx);
    assign w_syc = DW'(r_sy) - DW'(r_cy);
    assign w_pa = r_a * w_cxs;
    assign w_pb = w_syc * 9'sd200;
    assign w_a_mag = r_a[AW-1] ? AW'(-r_a) : r_a;
    assign w_recip = w_a_mag * 12'(RECIP_STEP);
    assign w_slope_idx = w_recip[23:16];
    // restoring root step: two bits of the radicand a cycle
    assign w_trial = {r_rem_n, r_sq[SQW-1 -: 2]} - {r_root, 2'b01};
    // restoring division step: one quotient bit a cycle
    assign w_rem_sh = {r_rem[NW-2:0], r_q[NW-1]};
    assign w_sub = {1'b0, w_rem_sh} - {1'b0, r_div};
    assign w_sum = {1'b0, r_d} + {1'b0, r_dc};

    assign o_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_have  <= 1'b0;
            r_cost  <= '0;
            r_bidx  <= '0;
            r_bx    <= '0;
            r_by    <= '0;
            o_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_sx <= i_start_x; r_sy <= i_start_y;
                        r_cx <= i_center_x; r_cy <= i_center_y;
                        r_hx <= i_handle_x; r_hy <= i_handle_y;
                        r_idx <= i_handle_index;
                        r_last <= i_last_handle;
                        r_state <= (i_handle_kind == i_wanted_kind) ? S_SQ1
                                 : (i_last_handle ? S_OUT : S_IDLE);
                    end
                end
                S_SQ1: begin
                    r_dx  <= w_dx;
                    r_dy  <= w_dy;
                    r_adx <= w_dx[DW-1] ? -w_dx : w_dx;
                    r_ady <= w_dy[DW-1] ? -w_dy : w_dy;
                    r_state <= S_SQ2;
                end
                S_SQ2: begin
                    r_sq <= SQW'(w_sqx) + SQW'(w_sqy);
                    r_rem_n <= '0;
                    r_root <= '0;
                    r_cnt <= '0;
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    if (!w_trial[SQW+1]) begin
                        r_rem_n <= w_trial[SQW-1:0];
                        r_root <= {r_root[RTW:0], 1'b1};
                    end else begin
                        r_rem_n <= SQW'({r_rem_n, r_sq[SQW-1 -: 2]});
                        r_root <= {r_root[RTW:0], 1'b0};
                    end
                    r_sq <= {r_sq[SQW-3:0], 2'b00};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(RSTEPS - 1)) r_state <= S_SHORT;
                end
                S_SHORT: begin
                    r_d <= COST_BITS'(r_root);
                    if (r_dy == 0 || ({r_ady, 4'b0} < {4'b0, r_adx})) begin
                        r_dc <= COST_BITS'(w_syc[DW-1] ? -w_syc : w_syc);
                        r_state <= S_CMP;
                    end else if (r_dx == 0 || ({r_adx, 4'b0} < {4'b0, r_ady})) begin
                        r_dc <= COST_BITS'(w_cxs[DW-1] ? -w_cxs : w_cxs);
                        r_state <= S_CMP;
                    end else begin
                        // |200*dy| / |dx|
                        r_q <= NW'(r_ady) * NW'(TABLE_ENTRIES);
                        r_rem <= '0;
                        r_div <= NW'(r_adx);
                        r_neg <= r_dx[DW-1] ^ r_dy[DW-1];
                        r_cnt <= '0;
                        r_state <= S_SDIV;
                    end
                end
                S_SDIV, S_DDIV: begin
                    if (!w_sub[NW]) begin
                        r_rem <= w_sub[NW-1:0];
                        r_q <= {r_q[NW-2:0], 1'b1};
                    end else begin
                        r_rem <= w_rem_sh;
                        r_q <= {r_q[NW-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(NW - 1))
                        r_state <= (r_state == S_SDIV) ? S_NUM1 : S_CMP;
                    if (r_state == S_DDIV && r_cnt == CW'(NW - 1))
                        r_dc <= COST_BITS'(w_sub[NW] ? {r_q[NW-2:0], 1'b0}
                                                     : {r_q[NW-2:0], 1'b1});
                end
                S_NUM1: begin
                    if (r_q > NW'(TABLE_ENTRIES * SLOPE_STEP))
                        r_a <= r_neg ? -AW'(TABLE_ENTRIES * SLOPE_STEP)
                                     : AW'(TABLE_ENTRIES * SLOPE_STEP);
                    else
                        r_a <= r_neg ? -AW'(r_q) : AW'(r_q);
                    r_state <= S_NUM2;
                end
                S_NUM2: begin
                    r_prod <= (NW+1)'(w_pa) + (NW+1)'(w_pb);
                    r_cnt <= '0;
                    r_rem <= '0;
                    r_state <= S_NUM3;
                    r_div <= NW'(w_norm_rom[w_slope_idx]);
                end
                S_NUM3: begin
                    r_q <= r_prod[NW] ? NW'(-r_prod) : NW'(r_prod);
                    r_state <= S_DDIV;
                end
                S_CMP: begin
                    if (!r_have || w_sum[COST_BITS-1:0] < r_cost) begin
                        r_have <= 1'b1;
                        r_cost <= w_sum[COST_BITS-1:0];
                        r_bidx <= r_idx;
                        r_bx <= r_hx;
                        r_by <= r_hy;
                    end
                    r_state <= r_last ? S_OUT : S_IDLE;
                end
                S_OUT: begin
                    if (!o_valid) begin
                        o_valid <= 1'b1;
                        o_found <= r_have;
                        o_best_index <= r_have ? r_bidx : '0;
                        o_best_x <= r_have ? r_bx : '0;
                        o_best_y <= r_have ? r_by : '0;
                        o_best_cost <= r_have ? r_cost : '0;
                        r_have <= 1'b0;
                        r_cost <= '0;
                        r_bidx <= '0;
                        r_bx <= '0;
                        r_by <= '0;
                    end else if (i_ready) begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `NHS_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_valid, !o_ready)
    `NHS_ASSERT_NXT(a_out_clears, i_clk, i_rst_n, o_valid && i_ready, !r_have)
    `NHS_ASSERT_IMP(a_found_cost, i_clk, i_rst_n, o_valid && !o_found, o_best_cost == '0)
endmodule

/* tb/nearest_handle_selector_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nearest_handle_selector_checker
// watches both channels, keeps a running best per query and compares every
// emitted choice with the predicted one, field by field, in order
// ----------------------------------------------------------------------------
module nearest_handle_selector_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    input  logic                                  i_in_ready,
    input  logic signed [nhs_pkg::COORD_BITS-1:0] i_start_x,
    input  logic signed [nhs_pkg::COORD_BITS-1:0] i_start_y,
    input  logic signed [nhs_pkg::COORD_BITS-1:0] i_center_x,
    input  logic signed [nhs_pkg::COORD_BITS-1:0] i_center_y,
    input  logic [nhs_pkg::KIND_BITS-1:0]         i_wanted_kind,
    input  logic [nhs_pkg::KIND_BITS-1:0]         i_handle_kind,
    input  logic [7:0]                            i_handle_index,
    input  logic signed [nhs_pkg::COORD_BITS-1:0] i_handle_x,
    input  logic signed [nhs_pkg::COORD_BITS-1:0] i_handle_y,
    input  logic                                  i_last_handle,
    input  logic                                  i_out_valid,
    input  logic                                  i_out_ready,
    input  logic                                  i_found,
    input  logic [7:0]                            i_best_index,
    input  logic signed [nhs_pkg::COORD_BITS-1:0] i_best_x,
    input  logic signed [nhs_pkg::COORD_BITS-1:0] i_best_y,
    input  logic [nhs_pkg::COST_BITS-1:0]         i_best_cost,
    output int                                    o_errors,
    output int                                    o_pending
);
    import nhs_pkg::*;

    typedef struct packed {
        logic                         found;
        logic [7:0]                   index;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic [COST_BITS-1:0]         cost;
    } t_choice;

    t_choice choice_q[$];
    t_choice best;
    logic    have_best;
    longint  norm_rom[0:TABLE_ENTRIES];

    function automatic longint root_floor(input longint n);
        longint r;
        r = 0;
        for (longint b = 64'd1 << 20; b > 0; b = b >> 1)
            if ((r + b) * (r + b) <= n) r = r + b;
        return r;
    endfunction

    function automatic longint mag(input longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint centre_offset(input longint sx, input longint sy,
                                             input longint hx, input longint hy,
                                             input longint cx, input longint cy);
        longint dx, dy, a, num;
        dx = hx - sx;
        dy = hy - sy;
        if (dy == 0 || mag(dy) * SHORTCUT < mag(dx)) return mag(sy - cy);
        if (dx == 0 || mag(dx) * SHORTCUT < mag(dy)) return mag(sx - cx);
        a = (TABLE_ENTRIES * dy) / dx;
        if (a < -TABLE_ENTRIES * SLOPE_STEP) a = -TABLE_ENTRIES * SLOPE_STEP;
        if (a > TABLE_ENTRIES * SLOPE_STEP) a = TABLE_ENTRIES * SLOPE_STEP;
        num = a * (cx - sx) + TABLE_ENTRIES * (sy - cy);
        return mag(num) / norm_rom[mag(a) / SLOPE_STEP];
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        o_errors++;
    endtask

    initial begin
        for (int i = 0; i <= TABLE_ENTRIES; i++) begin
            longint n;
            longint r;
            n = longint'(TABLE_ENTRIES) * TABLE_ENTRIES
                + longint'(i * SLOPE_STEP) * (i * SLOPE_STEP);
            r = root_floor(n);
            if (n - r * r > r) r++;
            norm_rom[i] = r;
        end
    end

    initial begin
        o_errors = 0;
        o_pending = 0;
        have_best = 0;
        best = '0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            have_best = 0;
            best = '0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                if (i_wanted_kind == i_handle_kind) begin
                    longint sx, sy, hx, hy, cost;
                    logic [COST_BITS-1:0] c;
                    sx = i_start_x;
                    sy = i_start_y;
                    hx = i_handle_x;
                    hy = i_handle_y;
                    cost = root_floor((sx - hx) * (sx - hx) + (sy - hy) * (sy - hy))
                         + centre_offset(sx, sy, hx, hy, i_center_x, i_center_y);
                    c = cost[COST_BITS-1:0];
                    if (!have_best || c < best.cost) begin
                        have_best = 1;
                        best = '{1'b1, i_handle_index, i_handle_x, i_handle_y, c};
                    end
                end
                if (i_last_handle) begin
                    choice_q.push_back(best);
                    have_best = 0;
                    best = '0;
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (choice_q.size() == 0) begin
                    report("unexpected result", 1, 0);
                end else begin
                    t_choice e;
                    e = choice_q.pop_front();
                    if (i_found !== e.found) report("found", i_found, e.found);
                    if (i_best_index !== e.index) report("index", i_best_index, e.index);
                    if (i_best_x !== e.x) report("x", i_best_x, e.x);
                    if (i_best_y !== e.y) report("y", i_best_y, e.y);
                    if (i_best_cost !== e.cost) report("cost", i_best_cost, e.cost);
                end
            end
        end
        o_pending = choice_q.size();
    end
endmodule

/* tb/nearest_handle_selector_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nearest_handle_selector_test
// drives queries of candidate handles with random gaps and output stalls,
// including one long output hold-off; the checker gives the verdict count
// ----------------------------------------------------------------------------
module nearest_handle_selector_test;
    import nhs_pkg::*;

    localparam int WATCHDOG = 20000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic o_ready;
    logic signed [COORD_BITS-1:0] i_start_x = 0, i_start_y = 0;
    logic signed [COORD_BITS-1:0] i_center_x = 0, i_center_y = 0;
    logic [KIND_BITS-1:0] i_wanted_kind = 0, i_handle_kind = 0;
    logic [7:0] i_handle_index = 0;
    logic signed [COORD_BITS-1:0] i_handle_x = 0, i_handle_y = 0;
    logic i_last_handle = 0;
    logic o_valid;
    logic i_ready = 0;
    logic o_found;
    logic [7:0] o_best_index;
    logic signed [COORD_BITS-1:0] o_best_x, o_best_y;
    logic [COST_BITS-1:0] o_best_cost;
    int errors, pending;
    int idle_cycles = 0;
    bit calm = 0;
    bit hold_off = 0;
    int hold_cycles = 0;

    always #4 i_clk = ~i_clk;

    nearest_handle_selector dut (.*);

    nearest_handle_selector_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_valid), .i_in_ready(o_ready),
        .i_start_x(i_start_x), .i_start_y(i_start_y),
        .i_center_x(i_center_x), .i_center_y(i_center_y),
        .i_wanted_kind(i_wanted_kind), .i_handle_kind(i_handle_kind),
        .i_handle_index(i_handle_index), .i_handle_x(i_handle_x),
        .i_handle_y(i_handle_y), .i_last_handle(i_last_handle),
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_found(o_found), .i_best_index(o_best_index),
        .i_best_x(o_best_x), .i_best_y(o_best_y), .i_best_cost(o_best_cost),
        .o_errors(errors), .o_pending(pending)
    );

    // receiver: random stall bursts, one long hold-off, none when calm
    initial begin
        int n;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off) begin
                i_ready <= 0;
                for (hold_cycles = 0; hold_cycles < 1500; hold_cycles++) @(posedge i_clk);
                hold_off = 0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 11);
                i_ready <= 0;
                repeat (n) @(posedge i_clk);
            end else begin
                i_ready <= 1;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || hold_off) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic signed [COORD_BITS-1:0] rand_coord(input int spread);
        case ($urandom_range(0, 5))
            0: return COORD_BITS'(-(1 <<< (COORD_BITS - 1)));
            1: return COORD_BITS'((1 <<< (COORD_BITS - 1)) - 1);
            2: return COORD_BITS'(int'($urandom_range(0, 2 * spread)) - spread);
            default: return COORD_BITS'($urandom);
        endcase
    endfunction

    task automatic send(input logic signed [COORD_BITS-1:0] sx, sy, cx, cy,
                        input logic [7:0] want, kind, idx,
                        input logic signed [COORD_BITS-1:0] hx, hy, input logic last);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_valid <= 1;
        i_start_x <= sx; i_start_y <= sy; i_center_x <= cx; i_center_y <= cy;
        i_wanted_kind <= want; i_handle_kind <= kind; i_handle_index <= idx;
        i_handle_x <= hx; i_handle_y <= hy; i_last_handle <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic random_query(input int spread);
        logic signed [COORD_BITS-1:0] sx, sy, cx, cy, hx, hy;
        logic [7:0] want;
        int len;
        sx = rand_coord(spread); sy = rand_coord(spread);
        cx = rand_coord(spread); cy = rand_coord(spread);
        want = 8'($urandom);
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
            hx = $urandom_range(0, 4) == 0 ? sx : rand_coord(spread);
            hy = $urandom_range(0, 4) == 0 ? sy : rand_coord(spread);
            // repeat a handle now and then to exercise ties
            if ($urandom_range(0, 7) == 0) begin
                hx = COORD_BITS'(sx + 7);
                hy = COORD_BITS'(sy + 3);
            end
            send(sx, sy, cx, cy, want, $urandom_range(0, 3) != 0 ? want : 8'($urandom),
                 8'($urandom), hx, hy, k == len - 1);
        end
    endtask

    initial begin
        logic signed [COORD_BITS-1:0] lo, hi;
        lo = COORD_BITS'(-(1 <<< (COORD_BITS - 1)));
        hi = COORD_BITS'((1 <<< (COORD_BITS - 1)) - 1);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: horizontal, vertical, sloped, extremes, ties, no match
        send(0, 0, 5, 9, 8'd3, 8'd3, 8'd1, 100, 2, 0);
        send(0, 0, 5, 9, 8'd3, 8'd3, 8'd2, 2, 100, 0);
        send(0, 0, 5, 9, 8'd3, 8'd3, 8'd3, 50, -40, 0);
        send(0, 0, 5, 9, 8'd3, 8'd3, 8'd4, 50, -40, 1);
        send(lo, lo, hi, hi, 8'hff, 8'hff, 8'hff, hi, hi, 1);
        send(hi, lo, lo, hi, 8'h00, 8'h00, 8'h00, lo, hi, 1);
        send(0, 0, 0, 0, 8'h00, 8'h00, 8'h80, 0, 0, 1);
        send(10, 10, -3, 7, 8'h55, 8'haa, 8'h11, 20, 20, 0);
        send(10, 10, -3, 7, 8'h55, 8'haa, 8'h12, 20, 20, 1);
        send(10, 10, -3, 7, 8'h55, 8'h55, 8'h13, 30, 900, 0);
        send(10, 10, -3, 7, 8'h55, 8'h01, 8'h14, 30, 30, 1);
        send(-5, 4, 300, -200, 8'h7f, 8'h7f, 8'h21, 1, 5, 0);
        send(-5, 4, 300, -200, 8'h7f, 8'h7f, 8'h22, -4, 12000, 1);
        for (int q = 0; q < 330; q++) begin
            if (q == 60) hold_off = 1;
            if (q == 290) calm = 1;
            random_query(q % 3 == 0 ? 16383 : 60);
        end
        i_valid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end
endmodule
